@@ src/tpm_pkg.sv @@
// Shared types, constants and helpers for the vario tone pattern mapper.
package tpm_pkg;

  // Climb-rate band of one request
  typedef enum logic [1:0] {
    BAND_DEAD,
    BAND_CLIMB,
    BAND_STRONG,
    BAND_SINK
  } band_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK_THR  = 1'b1;

  localparam logic signed [15:0] CLIMB_THR_RST = 16'sd128;
  localparam logic signed [15:0] SINK_THR_RST  = -16'sd282;

  // 10 m/s in Q8.8
  localparam logic signed [15:0] STRONG_CLIMB_RAW = 16'sd2560;

  // Climb band polynomials, scaled to Q.8 (frequency) and Q.16 (duration, period)
  localparam logic signed [24:0] FREQ_BASE  = 25'sd358400;    // 1400 * 256
  localparam logic signed [24:0] FREQ_SLOPE = 25'sd200;
  localparam logic signed [34:0] DUR_BASE   = 35'sd27525120;  // 420 * 65536
  localparam logic signed [34:0] DUR_LIN    = 35'sd5120;      // 20 * 256
  localparam logic signed [34:0] PER_BASE   = 35'sd36044800;  // 550 * 65536
  localparam logic signed [34:0] PER_LIN    = 35'sd7680;      // 30 * 256

  localparam logic [11:0] PITCH_LO_HZ = 12'd200;
  localparam logic [11:0] PITCH_HI_HZ = 12'd4000;
  localparam logic [11:0] DUR_MIN  = 12'd50;
  localparam logic [11:0] DUR_MAX  = 12'd500;
  localparam logic [11:0] PER_MIN  = 12'd100;
  localparam logic [11:0] PER_MAX  = 12'd1000;

  localparam logic [11:0] STRONG_FREQ = 12'd3450;
  localparam logic [8:0]  STRONG_DUR  = 9'd120;
  localparam logic [9:0]  STRONG_PER  = 10'd160;
  localparam logic [11:0] SINK_FREQ   = 12'd300;
  localparam logic [8:0]  SINK_DUR    = 9'd340;
  localparam logic [9:0]  SINK_PER    = 10'd200;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // One classified request waiting for the back end
  typedef struct packed {
    logic [11:0] freq;
    logic [8:0]  dur;
    logic [9:0]  per;
    logic [31:0] now;
    logic        act;
  } tone_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  // Clamp an already floored value; negatives land on the minimum
  function automatic logic [11:0] floor_clamp(input logic signed [34:0] q,
                                              input logic [11:0] lo,
                                              input logic [11:0] hi);
    logic signed [34:0] lo_s;
    logic signed [34:0] hi_s;
    logic [11:0]        res;
    lo_s = $signed({23'd0, lo});
    hi_s = $signed({23'd0, hi});
    if (q < lo_s) begin
      res = lo;
    end else if (q > hi_s) begin
      res = hi;
    end else begin
      res = q[11:0];
    end
    return res;
  endfunction

endpackage

@@ src/tpm_ifs.sv @@
// Request and result channel interfaces.
interface tpm_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] climb_rate;
  logic [31:0]        time_now;
  logic               action;

  modport source (output valid, climb_rate, time_now, action, input ready);
  modport sink   (input valid, climb_rate, time_now, action, output ready);
endinterface

interface tpm_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] tone_frequency;
  logic [8:0]  tone_duration;
  logic [9:0]  tone_period;
  logic        beep_due;

  modport source (output valid, tone_frequency, tone_duration, tone_period, beep_due,
                  input ready);
  modport sink   (input valid, tone_frequency, tone_duration, tone_period, beep_due,
                  output ready);
endinterface

@@ src/tpm_front.sv @@
// Front end: accepts requests, classifies the band, computes the tone values.
module tpm_front (
  input  logic                 clk,
  input  logic                 rst,
  tpm_req_if.sink              sample,
  input  logic signed [15:0]   climb_thr,
  input  logic signed [15:0]   sink_thr,
  output logic                 push_valid,
  input  logic                 push_ready,
  output tpm_pkg::tone_t       push_entry
);

  logic                s1_valid;
  logic signed [15:0]  s1_r;
  logic signed [31:0]  s1_sq;
  tpm_pkg::band_t      s1_band;
  logic [31:0]         s1_now;
  logic                s1_act;

  tpm_pkg::band_t      band_in;
  logic                take;

  logic signed [24:0]  r25;
  logic signed [24:0]  freq_num;
  logic signed [34:0]  r35;
  logic signed [34:0]  sq35;
  logic signed [34:0]  dur_num;
  logic signed [34:0]  per_num;
  logic [11:0]         freq_c;
  logic [11:0]         dur_c;
  logic [11:0]         per_c;

  assign sample.ready = !s1_valid || push_ready;
  assign take         = sample.valid && sample.ready;

  always_comb begin
    if (sample.climb_rate > climb_thr && sample.climb_rate <= tpm_pkg::STRONG_CLIMB_RAW) begin
      band_in = tpm_pkg::BAND_CLIMB;
    end else if (sample.climb_rate > tpm_pkg::STRONG_CLIMB_RAW) begin
      band_in = tpm_pkg::BAND_STRONG;
    end else if (sample.climb_rate < sink_thr) begin
      band_in = tpm_pkg::BAND_SINK;
    end else begin
      band_in = tpm_pkg::BAND_DEAD;
    end
  end

  // stage 1: capture, classify, square
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
    if (take) begin
      s1_r    <= sample.climb_rate;
      s1_sq   <= 32'(sample.climb_rate) * 32'(sample.climb_rate);
      s1_band <= band_in;
      s1_now  <= sample.time_now;
      s1_act  <= sample.action;
    end
  end

  // stage 2: polynomial sums, floor, clamp
  always_comb begin
    r25      = 25'(s1_r);
    freq_num = tpm_pkg::FREQ_BASE + r25 * tpm_pkg::FREQ_SLOPE;
    r35      = 35'(s1_r);
    sq35     = 35'(s1_sq);
    dur_num  = tpm_pkg::DUR_BASE - sq35 - r35 * tpm_pkg::DUR_LIN;
    per_num  = tpm_pkg::PER_BASE - sq35 - r35 * tpm_pkg::PER_LIN;
    freq_c   = tpm_pkg::floor_clamp(35'(freq_num >>> 8), tpm_pkg::PITCH_LO_HZ,
                                    tpm_pkg::PITCH_HI_HZ);
    dur_c    = tpm_pkg::floor_clamp(dur_num >>> 16, tpm_pkg::DUR_MIN, tpm_pkg::DUR_MAX);
    per_c    = tpm_pkg::floor_clamp(per_num >>> 16, tpm_pkg::PER_MIN, tpm_pkg::PER_MAX);

    push_entry.now = s1_now;
    push_entry.act = s1_act;
    case (s1_band)
      tpm_pkg::BAND_CLIMB: begin
        push_entry.freq = freq_c;
        push_entry.dur  = dur_c[8:0];
        push_entry.per  = per_c[9:0];
      end
      tpm_pkg::BAND_STRONG: begin
        push_entry.freq = tpm_pkg::STRONG_FREQ;
        push_entry.dur  = tpm_pkg::STRONG_DUR;
        push_entry.per  = tpm_pkg::STRONG_PER;
      end
      tpm_pkg::BAND_SINK: begin
        push_entry.freq = tpm_pkg::SINK_FREQ;
        push_entry.dur  = tpm_pkg::SINK_DUR;
        push_entry.per  = tpm_pkg::SINK_PER;
      end
      default: begin
        push_entry.freq = '0;
        push_entry.dur  = '0;
        push_entry.per  = '0;
      end
    endcase
  end

  assign push_valid = s1_valid;

endmodule

@@ src/tpm_queue.sv @@
// Short FIFO between front and back end.
module tpm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  tpm_pkg::tone_t    push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tpm_pkg::tone_t    pop_entry,
  output tpm_pkg::q_stat_t  stat
);

  tpm_pkg::tone_t                 mem [tpm_pkg::QDEPTH];
  logic [tpm_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tpm_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tpm_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign stat.count = count;
  assign stat.full  = (count == tpm_pkg::QCNT_W'(tpm_pkg::QDEPTH));
  assign stat.empty = (count == '0);

  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ src/tpm_back.sv @@
// Back end: beep-due check against the last beep time, result register.
module tpm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  tpm_pkg::tone_t  pop_entry,
  tpm_res_if.source       result
);

  logic        out_valid;
  logic [31:0] last_beep_time;
  logic [31:0] elapsed;
  logic        take;

  assign pop_ready = !out_valid || result.ready;
  assign take      = pop_valid && pop_ready;
  assign elapsed   = pop_entry.now - last_beep_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_beep_time <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        if (pop_entry.act) begin
          last_beep_time <= pop_entry.now;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      result.tone_frequency <= pop_entry.freq;
      result.tone_duration  <= pop_entry.dur;
      result.tone_period    <= pop_entry.per;
      result.beep_due       <= (elapsed >= {22'd0, pop_entry.per});
    end
  end

  assign result.valid = out_valid;

endmodule

@@ src/vario_tone_pattern_mapper.sv @@
// Top level of the vario tone pattern mapper.
//
//   channel  | dir | payload                                          | accept
//   ---------+-----+--------------------------------------------------+------------------
//   sample   | in  | climb_rate, time_now, action                     | valid & ready
//   result   | out | tone_frequency, tone_duration, tone_period,      | valid & ready
//            |     | beep_due                                         |
//   cfg      | in  | cfg_we, cfg_index, cfg_wdata                     | cfg_we
//
// One request per cycle sustained while the result side keeps taking them.
// An accepted sample loads the capture stage (with the 16x16 square) first;
// its sums and clamps then feed the four-deep queue write, and the back end
// register loads from the queue last. Stalls can hold a request between them.
// Synchronous active-high reset clears the pipeline, queue, the last beep time
// (to zero) and loads the default thresholds.
// A stalled result side fills the queue first; sample ready drops only once
// the queue and the front stage are both full.
module vario_tone_pattern_mapper (
  input  logic                          clk,
  input  logic                          rst,
  tpm_req_if.sink                       sample,
  tpm_res_if.source                     result,
  input  logic                          cfg_we,
  input  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  logic signed [15:0] climb_thr;
  logic signed [15:0] sink_thr;

  logic               push_valid;
  logic               push_ready;
  tpm_pkg::tone_t     push_entry;
  logic               pop_valid;
  logic               pop_ready;
  tpm_pkg::tone_t     pop_entry;
  tpm_pkg::q_stat_t   q_stat;

  // Threshold registers, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      climb_thr <= tpm_pkg::CLIMB_THR_RST;
      sink_thr  <= tpm_pkg::SINK_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tpm_pkg::CFG_CLIMB_THR: climb_thr <= $signed(cfg_wdata);
        tpm_pkg::CFG_SINK_THR:  sink_thr  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  tpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .climb_thr  (climb_thr),
    .sink_thr   (sink_thr),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  tpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  tpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .result    (result)
  );

  // Dead band: silent tone always reports the beep as due
  a_dead_band: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.tone_frequency == 12'd0 |->
      result.tone_duration == 9'd0 && result.tone_period == 10'd0 && result.beep_due)
    else $error("dead band result not all zero or beep not due");

  // Any sounding tone sits at or above the clamp minimums
  a_tone_floor: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.tone_period != 10'd0 |->
      result.tone_frequency >= 12'd200 && result.tone_duration >= 9'd50 &&
      result.tone_period >= 10'd100)
    else $error("sounding tone below clamp minimum");

  // A new result needs a queued request behind it
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!q_stat.empty))
    else $error("result appeared with queue empty");

  // Queue never passes its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |=> q_stat.count <= tpm_pkg::QCNT_W'(tpm_pkg::QDEPTH))
    else $error("queue overflow");

endmodule

@@ tb/vario_tone_pattern_mapper_test.sv @@
// Self-checking bench, vario tone pattern mapper: directed bands, timing, thresholds, then random traffic.
module vario_tone_pattern_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no request or result accepted before the run is abandoned.
  // The longest legal quiet stretch is a sender gap or a receiver stall, so
  // this is generous.
  localparam int WATCHDOG_LIMIT = 2000;

  // 10 m/s in Q8.8: above this the strong climb pattern applies
  localparam int STRONG_CLIMB_Q8 = 2560;

  // Receiver behavior, re-picked every window
  typedef enum logic [2:0] {
    TAKE_ALL,      // ready every cycle
    TAKE_RANDOM,   // coin flip per cycle
    TAKE_SPARSE,   // ready a quarter of the time, on a repeating pattern
    TAKE_MOSTLY,   // ready with probability three in four
    TAKE_LATE      // long stall, then a short open window
  } take_mode_t;

  localparam int TAKE_WINDOW = 48;

  // One expected tone result, at the block's output widths
  typedef struct {
    logic [11:0] freq;
    logic [8:0]  dur;
    logic [9:0]  per;
    logic        due;
  } tone_pattern_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_wdata;

  tpm_req_if sample_ch();
  tpm_res_if result_ch();

  vario_tone_pattern_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state: thresholds as last written, and the last beep time
  int            climb_thr;
  int            sink_thr;
  logic [31:0]   last_beep;
  logic [31:0]   clock_ms;      // running time base for random requests

  tone_pattern_t expected_tones[$];
  int            errors;
  int            burst_left;    // requests left in the current sender burst
  int            idle_cycles;
  take_mode_t    take_mode;
  int            take_count;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor a non-negative fixed-point value by shift, then clamp. Any negative
  // intermediate lands on the minimum.
  function automatic int floor_limit(longint num, int shift, int lo, int hi);
    longint q;
    if (num < 0) return lo;
    q = num >>> shift;
    if (q < lo) return lo;
    if (q > hi) return hi;
    return int'(q);
  endfunction

  function automatic tone_pattern_t predict_tone(logic signed [15:0] rate, logic [31:0] now);
    tone_pattern_t t;
    longint        v;
    logic [31:0]   elapsed;
    v      = rate;
    t.freq = '0;
    t.dur  = '0;
    t.per  = '0;
    if (v > climb_thr && v <= STRONG_CLIMB_Q8) begin
      // 1400 + 200v in Q.8; 420 - v(20+v) and 550 - v(30+v) in Q.16
      t.freq = 12'(floor_limit(1400 * 256 + 200 * v, 8, 200, 4000));
      t.dur  = 9'(floor_limit(64'sd420 * 65536 - v * (20 * 256 + v), 16, 50, 500));
      t.per  = 10'(floor_limit(64'sd550 * 65536 - v * (30 * 256 + v), 16, 100, 1000));
    end else if (v > STRONG_CLIMB_Q8) begin
      // strong climb wins regardless of the climb threshold
      t.freq = 12'd3450;
      t.dur  = 9'd120;
      t.per  = 10'd160;
    end else if (v < sink_thr) begin
      t.freq = 12'd300;
      t.dur  = 9'd340;
      t.per  = 10'd200;
    end
    // modular elapsed time; the dead band's zero period is always due
    elapsed = now - last_beep;
    t.due   = (elapsed >= {22'd0, t.per});
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request. Bursts of random length, with random gaps between them;
  // a zero gap keeps valid high straight across the burst boundary.
  task automatic send_sample(input logic signed [15:0] rate, input logic [31:0] now,
                             input logic act);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        sample_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    sample_ch.valid      <= 1'b1;
    sample_ch.climb_rate <= rate;
    sample_ch.time_now   <= now;
    sample_ch.action     <= act;
    do @(posedge clk); while (!sample_ch.ready);
    expected_tones.push_back(predict_tone(rate, now));
    // the beep is recorded after evaluation of the same request
    if (act) last_beep = now;
    burst_left--;
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_tones.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpm_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == tpm_pkg::CFG_CLIMB_THR) climb_thr = int'($signed(data));
    else sink_thr = int'($signed(data));
  endtask

  // Thresholds change only with the pipe empty
  task automatic set_thresholds(input int climb, input int sink);
    drain_results();
    write_reg(tpm_pkg::CFG_CLIMB_THR, 16'(climb));
    write_reg(tpm_pkg::CFG_SINK_THR, 16'(sink));
  endtask

  // Climb rates aimed at band edges, with full-range noise mixed in
  function automatic logic signed [15:0] pick_climb_rate();
    int r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r = int'($urandom_range(0, 6000)) - 3000;
      4:          r = climb_thr + int'($urandom_range(0, 6)) - 3;
      5:          r = sink_thr + int'($urandom_range(0, 6)) - 3;
      6:          r = STRONG_CLIMB_Q8 + int'($urandom_range(0, 6)) - 3;
      7, 8:       r = int'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0:       r = -32768;
          1:       r = 32767;
          2:       r = 0;
          default: r = -1;
        endcase
      end
    endcase
    return 16'(r);
  endfunction

  // Mostly forward steps around the beep periods, some jumps and wraps
  function automatic logic [31:0] next_time();
    case ($urandom_range(0, 15))
      0:       clock_ms = $urandom();
      1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 900);
      default: clock_ms = clock_ms + $urandom_range(0, 700);
    endcase
    return clock_ms;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver stalls follow a mode picked anew every window
  always @(negedge clk) begin
    if (take_count == TAKE_WINDOW - 1) begin
      take_count <= 0;
      take_mode  <= take_mode_t'($urandom_range(0, 4));
    end else begin
      take_count <= take_count + 1;
    end
    case (take_mode)
      TAKE_ALL:    result_ch.ready <= 1'b1;
      TAKE_RANDOM: result_ch.ready <= $urandom_range(0, 1);
      TAKE_SPARSE: result_ch.ready <= (take_count % 8) < 2;
      TAKE_MOSTLY: result_ch.ready <= $urandom_range(0, 3) != 0;
      default:     result_ch.ready <= take_count >= 40;
    endcase
  end

  function automatic void check_field(string label, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endfunction

  // Each accepted result is compared with the oldest expectation
  always @(posedge clk) begin
    tone_pattern_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_tones.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual freq %0d dur %0d per %0d due %0d",
                 $time, result_ch.tone_frequency, result_ch.tone_duration,
                 result_ch.tone_period, result_ch.beep_due);
      end else begin
        want = expected_tones.pop_front();
        check_field("tone_frequency", want.freq, result_ch.tone_frequency);
        check_field("tone_duration", want.dur, result_ch.tone_duration);
        check_field("tone_period", want.per, result_ch.tone_period);
        check_field("beep_due", want.due, result_ch.beep_due);
      end
    end
  end

  // Watchdog: quiet cycles on both channels
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Band boundaries at the reset thresholds; time held at zero
  task automatic test_band_edges();
    send_sample(16'sd128, 32'd0, 1'b0);      // equal to climb threshold: dead band
    send_sample(16'sd129, 32'd0, 1'b0);      // just inside climb band
    send_sample(16'sd256, 32'd0, 1'b0);      // 1 m/s
    send_sample(16'sd1000, 32'd0, 1'b0);
    send_sample(16'sd2560, 32'd0, 1'b0);     // top of climb band
    send_sample(16'sd2561, 32'd0, 1'b0);     // strong climb
    send_sample(16'sd32767, 32'd0, 1'b0);
    send_sample(-16'sd282, 32'd0, 1'b0);     // equal to sink threshold: dead band
    send_sample(-16'sd283, 32'd0, 1'b0);     // sink alarm
    send_sample(-16'sd32768, 32'd0, 1'b0);
  endtask

  // Beep due against the period, exact edges and the 32-bit wrap
  task automatic test_beep_timing();
    send_sample(16'sd0, 32'd1000, 1'b1);             // dead band, always due
    send_sample(16'sd2600, 32'd1159, 1'b0);          // one short of 160
    send_sample(16'sd2600, 32'd1160, 1'b1);          // exactly 160
    send_sample(-16'sd1000, 32'd1359, 1'b0);         // one short of 200
    send_sample(16'sd0, 32'hFFFF_FF9C, 1'b1);
    send_sample(-16'sd400, 32'h0000_0063, 1'b0);     // across the wrap: 199
    send_sample(-16'sd400, 32'h0000_0064, 1'b0);     // across the wrap: 200
    send_sample(16'sd2561, 32'hFFFF_FE00, 1'b1);     // time ran backward: huge elapsed
  endtask

  // Threshold extremes and out-of-order thresholds
  task automatic test_threshold_extremes();
    // climb band covers nearly everything; negative intermediates clamp low
    set_thresholds(-32768, 32767);
    send_sample(-16'sd32767, 32'd0, 1'b0);
    send_sample(-16'sd32768, 32'd0, 1'b0);  // not above climb, below sink
    send_sample(-16'sd1, 32'd0, 1'b0);
    send_sample(-16'sd2560, 32'd0, 1'b0);   // duration clamps on the high side
    // climb band empty; strong climb still applies, nothing below sink
    set_thresholds(32767, -32768);
    send_sample(16'sd2561, 32'd0, 1'b0);
    send_sample(-16'sd32768, 32'd0, 1'b0);
    // crossed thresholds: climb band tested first
    set_thresholds(-500, 500);
    send_sample(16'sd0, 32'd0, 1'b0);
    send_sample(-16'sd600, 32'd0, 1'b0);
  endtask

  // Random requests under several threshold settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_thresholds(128, -282);
        1:       set_thresholds(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))));
        2:       set_thresholds(-32768, 32767);
        3:       set_thresholds(32767, -32768);
        default: set_thresholds(int'($urandom_range(0, 1600)) - 800,
                                int'($urandom_range(0, 1800)) - 1500);
      endcase
      if (phase == 2) clock_ms = 32'hFFFF_F000;
      repeat (80) send_sample(pick_climb_rate(), next_time(), $urandom_range(0, 2) == 0);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    sample_ch.valid      = 1'b0;
    sample_ch.climb_rate = '0;
    sample_ch.time_now   = '0;
    sample_ch.action     = 1'b0;
    result_ch.ready      = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = tpm_pkg::CFG_CLIMB_THR;
    cfg_wdata            = '0;
    climb_thr            = 128;
    sink_thr             = -282;
    last_beep            = '0;
    clock_ms             = '0;
    errors               = 0;
    burst_left           = 0;
    idle_cycles          = 0;
    take_mode            = TAKE_ALL;
    take_count           = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_band_edges();
    test_beep_timing();
    test_threshold_extremes();
    test_random_traffic();

    drain_results();
    // let any stray result surface
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_tones.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
